FILE: hw/rtl/lbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared constants and types for the buffer cache tag store.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int IDX_W     = $clog2(NUM_SLOTS + 1);
    localparam int COUNT_W   = 8;
    localparam int KEY_W     = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    localparam logic [1:0] KIND_GET     = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_PIN     = 2'd2;
    localparam logic [1:0] KIND_UNPIN   = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic              hit_found;
        logic [SLOT_W-1:0] hit_slot;
        logic              vic_found;
        logic [SLOT_W-1:0] vic_slot;
    } t_scan_result;

endpackage
`default_nettype wire

FILE: hw/rtl/lbc_scan_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_scan_unit
// Examines one slot per cycle and keeps the most recent tag match and the
// least recent slot with a zero reference count.
// ----------------------------------------------------------------------------
module lbc_scan_unit
    import lbc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_clear,
    input  wire logic              i_valid,
    input  wire logic [KEY_W-1:0]  i_tag,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic [SLOT_W-1:0] i_rank,
    input  wire logic [SLOT_W-1:0] i_slot,
    input  wire logic              i_zero_count,
    output t_scan_result           o_result
);

    logic              r_hit_found;
    logic [SLOT_W-1:0] r_hit_rank;
    logic [SLOT_W-1:0] r_hit_slot;
    logic              r_vic_found;
    logic [SLOT_W-1:0] r_vic_rank;
    logic [SLOT_W-1:0] r_vic_slot;
    logic              take_hit;
    logic              take_vic;

    assign take_hit = i_valid && (i_tag == i_key) && (!r_hit_found || (i_rank < r_hit_rank));
    assign take_vic = i_valid && i_zero_count && (!r_vic_found || (i_rank > r_vic_rank));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_found <= 1'b0;
            r_vic_found <= 1'b0;
        end else if (i_clear) begin
            r_hit_found <= 1'b0;
            r_vic_found <= 1'b0;
        end else begin
            if (take_hit) begin
                r_hit_found <= 1'b1;
            end
            if (take_vic) begin
                r_vic_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_hit) begin
            r_hit_rank <= i_rank;
            r_hit_slot <= i_slot;
        end
        if (take_vic) begin
            r_vic_rank <= i_rank;
            r_vic_slot <= i_slot;
        end
    end

    assign o_result.hit_found = r_hit_found;
    assign o_result.hit_slot  = r_hit_slot;
    assign o_result.vic_found = r_vic_found;
    assign o_result.vic_slot  = r_vic_slot;

endmodule
`default_nettype wire

FILE: hw/rtl/lru_block_buffer_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// Buffer cache tag store with reference counts and least recently released
// replacement, driven by a small sequencer around one slot compare unit.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_stall    i_kind, i_device,
//                                                 i_block_number, i_slot
//  out      output     o_out_valid / i_out_stall  o_slot_out, o_hit,
//                                                 o_needs_read, o_status,
//                                                 o_count_after
//
// A get visits every slot: the compare unit examines one slot per cycle
// through the registered tag memory read.
// Release, pin and unpin skip the scan and go straight to the apply state.
// Reset is synchronous and clears all tag valid bits so every tag reads as zero,
// sets all counts to zero and sets the recency order to slot 0 least recent.
// A new transaction is accepted while a finished result still waits on a stall.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache
    import lbc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_device,
    input  wire logic [31:0] i_block_number,
    input  wire logic [4:0]  i_slot,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [4:0]       o_slot_out,
    output logic             o_hit,
    output logic             o_needs_read,
    output logic [1:0]       o_status,
    output logic [7:0]       o_count_after
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_PICK  = 2'd2;
    localparam logic [1:0] ST_APPLY = 2'd3;

    localparam logic [IDX_W-1:0] IDX_END = IDX_W'(NUM_SLOTS);

    logic [1:0]         r_state;
    logic [1:0]         r_kind;
    logic [7:0]         r_device;
    logic [31:0]        r_block;
    logic [4:0]         r_slot_in;
    logic               r_in_range;
    logic [SLOT_W-1:0]  r_sel;
    logic [IDX_W-1:0]   r_idx;
    logic               r_cmp_vld;

    logic [KEY_W-1:0]   tag_mem [NUM_SLOTS];
    logic [KEY_W-1:0]   r_tag_rd;
    logic               r_tag_ok_rd;
    logic [NUM_SLOTS-1:0] r_tag_ok;
    logic [NUM_SLOTS-1:0] r_contents_valid;
    logic [COUNT_W-1:0] r_count [NUM_SLOTS];
    logic [SLOT_W-1:0]  r_rank [NUM_SLOTS];

    logic               r_out_valid;
    logic [4:0]         r_slot_out;
    logic               r_hit;
    logic               r_needs_read;
    logic [1:0]         r_status;
    logic [7:0]         r_count_after;

    logic               accept_in;
    logic               out_free;
    logic               issue;
    logic               tag_we;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   tag_eff;
    logic [COUNT_W-1:0] sel_count;
    logic [COUNT_W-1:0] sel_count_inc;
    logic [SLOT_W-1:0]  sel_rank;
    logic               sel_valid;
    t_scan_result       scan_res;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept_in  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign issue      = (r_state == ST_SCAN) && (r_idx < IDX_END);

    assign key           = {r_device, r_block};
    assign tag_eff       = r_tag_ok_rd ? r_tag_rd : '0;
    assign sel_count     = r_count[r_sel];
    assign sel_count_inc = (sel_count == COUNT_MAX) ? sel_count : sel_count + 1'b1;
    assign sel_rank      = r_rank[r_sel];
    assign sel_valid     = r_contents_valid[r_sel];

    assign tag_we = (r_state == ST_APPLY) && out_free && (r_kind == KIND_GET)
                    && !scan_res.hit_found && scan_res.vic_found;

    lbc_scan_unit u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (accept_in),
        .i_valid      ((r_state == ST_SCAN) && r_cmp_vld),
        .i_tag        (tag_eff),
        .i_key        (key),
        .i_rank       (sel_rank),
        .i_slot       (r_sel),
        .i_zero_count (sel_count == '0),
        .o_result     (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_tag_rd <= tag_mem[r_idx[SLOT_W-1:0]];
        end
        if (tag_we) begin
            tag_mem[r_sel] <= key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_kind    <= i_kind;
            r_device  <= i_device;
            r_block   <= i_block_number;
            r_slot_in <= i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_cmp_vld        <= 1'b0;
            r_idx            <= '0;
            r_in_range       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_tag_ok         <= '0;
            r_contents_valid <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_count[i] <= '0;
                r_rank[i]  <= SLOT_W'(NUM_SLOTS - 1 - i);
            end
        end else begin
            if ((r_state == ST_APPLY) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept_in) begin
                        r_cmp_vld <= 1'b0;
                        r_idx     <= '0;
                        if (i_kind == KIND_GET) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_sel      <= SLOT_W'(i_slot);
                            r_in_range <= (32'(i_slot) < 32'(NUM_SLOTS));
                            r_state    <= ST_APPLY;
                        end
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        r_sel       <= r_idx[SLOT_W-1:0];
                        r_tag_ok_rd <= r_tag_ok[r_idx[SLOT_W-1:0]];
                        r_cmp_vld   <= 1'b1;
                        r_idx       <= r_idx + 1'b1;
                    end else begin
                        r_cmp_vld <= 1'b0;
                        r_state   <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    r_sel   <= scan_res.hit_found ? scan_res.hit_slot : scan_res.vic_slot;
                    r_state <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (out_free) begin
                        r_hit         <= 1'b0;
                        r_needs_read  <= 1'b0;
                        r_status      <= STATUS_OK;
                        r_count_after <= '0;
                        r_slot_out    <= 5'd0;
                        r_state       <= ST_IDLE;
                        if (r_kind == KIND_GET) begin
                            if (scan_res.hit_found) begin
                                r_count[r_sel]          <= sel_count_inc;
                                r_contents_valid[r_sel] <= 1'b1;
                                r_hit                   <= 1'b1;
                                r_needs_read            <= !sel_valid;
                                r_count_after           <= sel_count_inc;
                                r_slot_out              <= 5'(r_sel);
                            end else if (scan_res.vic_found) begin
                                r_count[r_sel]          <= COUNT_W'(1);
                                r_contents_valid[r_sel] <= 1'b1;
                                r_tag_ok[r_sel]         <= 1'b1;
                                r_needs_read            <= 1'b1;
                                r_count_after           <= COUNT_W'(1);
                                r_slot_out              <= 5'(r_sel);
                            end else begin
                                r_status <= STATUS_NO_FREE;
                            end
                        end else begin
                            r_slot_out <= r_slot_in;
                            if (r_in_range) begin
                                if (r_kind == KIND_PIN) begin
                                    r_count[r_sel] <= sel_count_inc;
                                    r_count_after  <= sel_count_inc;
                                end else if (sel_count == '0) begin
                                    r_status <= STATUS_UNDERFLOW;
                                end else begin
                                    r_count[r_sel] <= sel_count - 1'b1;
                                    r_count_after  <= sel_count - 1'b1;
                                    if ((r_kind == KIND_RELEASE) && (sel_count == COUNT_W'(1))) begin
                                        for (int i = 0; i < NUM_SLOTS; i++) begin
                                            if (r_rank[i] < sel_rank) begin
                                                r_rank[i] <= r_rank[i] + 1'b1;
                                            end
                                        end
                                        r_rank[r_sel] <= '0;
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot_out    = r_slot_out;
    assign o_hit         = r_hit;
    assign o_needs_read  = r_needs_read;
    assign o_status      = r_status;
    assign o_count_after = r_count_after;

endmodule
`default_nettype wire
